FILE: rtl/wildcard_byte_pattern_scanner_core_macros.svh
// Assertion macros used by the scanner core.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH

`ifndef SYNTH
// Checks that the consequent holds in the same cycle as the antecedent.
`define WBPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");
`else
`define WBPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/wbps_pkg.sv
package wbps_pkg;

    // Pattern bytes held by the configuration registers.
    localparam int PAT_BYTES = 32;
    localparam int PAT_IDX_W = $clog2(PAT_BYTES);
    localparam int LEN_W = 6;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PATTERN_MAX_DEFAULT = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LENGTH  = 3'd0,
        REG_PATTERN_BYTES_0 = 3'd1,
        REG_PATTERN_BYTES_1 = 3'd2,
        REG_PATTERN_BYTES_2 = 3'd3,
        REG_PATTERN_BYTES_3 = 3'd4,
        REG_WILDCARD_MASK   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] byte_offset;
        logic        region_start;
        logic        end_of_scan;
    } scan_item_t;

    typedef struct packed {
        logic [31:0] match_count;
        logic [31:0] first_match_offset;
        logic        unique_match;
    } result_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             length_ok;
    } pattern_ctl_t;

    typedef struct packed {
        logic        fire;
        logic        last;
        logic        hit;
        logic [31:0] start_offset;
    } tally_step_t;

endpackage

FILE: rtl/wbps_cell.sv
module wbps_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    input  logic [7:0] ref_byte,
    input  logic       care,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !care || (byte_reg == ref_byte);

endmodule

FILE: rtl/wbps_cfg.sv
module wbps_cfg #(
    parameter int WIN = wbps_pkg::PAT_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wbps_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wbps_pkg::pattern_ctl_t              ctl,
    output logic [WIN-1:0][7:0]                 ref_bytes,
    output logic [WIN-1:0]                      care
);

    localparam int LW = wbps_pkg::LEN_W;
    localparam int PB = wbps_pkg::PAT_BYTES;
    localparam int IW = wbps_pkg::PAT_IDX_W;

    logic [LW-1:0]        pattern_length_reg, pattern_length_next;
    logic [PB-1:0][7:0]   pattern_bytes_reg, pattern_bytes_next;
    logic [PB-1:0]        wildcard_mask_reg, wildcard_mask_next;
    logic [WIN-1:0][7:0]  ref_bytes_reg, ref_bytes_next;
    logic [WIN-1:0]       care_reg, care_next;
    logic                 length_ok_reg, length_ok_next;

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        pattern_bytes_next  = pattern_bytes_reg;
        wildcard_mask_next  = wildcard_mask_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                wbps_pkg::REG_PATTERN_LENGTH:  pattern_length_next = cfg_data[LW-1:0];
                wbps_pkg::REG_PATTERN_BYTES_0: pattern_bytes_next[7:0] = cfg_data;
                wbps_pkg::REG_PATTERN_BYTES_1: pattern_bytes_next[15:8] = cfg_data;
                wbps_pkg::REG_PATTERN_BYTES_2: pattern_bytes_next[23:16] = cfg_data;
                wbps_pkg::REG_PATTERN_BYTES_3: pattern_bytes_next[31:24] = cfg_data;
                wbps_pkg::REG_WILDCARD_MASK:   wildcard_mask_next = cfg_data[PB-1:0];
                default: ;
            endcase
        end
    end

    // Window entry j holds the byte that pattern position length-1-j must match,
    // so the pattern is turned around once here rather than per byte.
    always_comb
    begin
        logic [LW-1:0] idx;
        length_ok_next = (pattern_length_next != '0) &&
                         (pattern_length_next <= LW'(WIN));
        for (int j = 0; j < WIN; j++)
        begin
            idx = LW'(pattern_length_next - LW'(j) - LW'(1));
            ref_bytes_next[j] = pattern_bytes_next[idx[IW-1:0]];
            care_next[j] = (LW'(j) < pattern_length_next) && !wildcard_mask_next[idx[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_bytes_reg  <= '0;
            wildcard_mask_reg  <= '0;
            ref_bytes_reg      <= '0;
            care_reg           <= '0;
            length_ok_reg      <= 1'b0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            pattern_bytes_reg  <= pattern_bytes_next;
            wildcard_mask_reg  <= wildcard_mask_next;
            ref_bytes_reg      <= ref_bytes_next;
            care_reg           <= care_next;
            length_ok_reg      <= length_ok_next;
        end
    end

    assign ctl.length    = pattern_length_reg;
    assign ctl.length_ok = length_ok_reg;
    assign ref_bytes     = ref_bytes_reg;
    assign care          = care_reg;

endmodule

FILE: rtl/wbps_tally.sv
module wbps_tally (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wbps_pkg::tally_step_t  step,
    input  logic                   result_ready,
    output logic                   result_valid,
    output wbps_pkg::result_item_t result_item
);

    logic [31:0]            match_total_reg, match_total_next;
    logic [31:0]            first_offset_reg, first_offset_next;
    logic                   result_valid_reg, result_valid_next;
    wbps_pkg::result_item_t result_item_reg, result_item_next;
    logic [31:0]            total_upd;
    logic [31:0]            first_upd;

    always_comb
    begin
        total_upd = match_total_reg;
        first_upd = first_offset_reg;
        if (step.fire && step.hit)
        begin
            if (match_total_reg == '0)
            begin
                first_upd = step.start_offset;
            end
            if (match_total_reg != '1)
            begin
                total_upd = match_total_reg + 32'd1;
            end
        end

        match_total_next  = total_upd;
        first_offset_next = first_upd;
        result_item_next  = result_item_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (step.fire && step.last)
        begin
            result_item_next.match_count        = total_upd;
            result_item_next.first_match_offset = (total_upd != '0) ? first_upd : '0;
            result_item_next.unique_match       = (total_upd == 32'd1);
            result_valid_next = 1'b1;
            match_total_next  = '0;
            first_offset_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_total_reg  <= '0;
            first_offset_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            match_total_reg  <= match_total_next;
            first_offset_reg <= first_offset_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_item_reg <= result_item_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

FILE: rtl/wildcard_byte_pattern_scanner_core.sv
// Scans one byte per clock for a wildcard byte pattern of up to 32 bytes. Bytes
// shift through a row of window cells, each comparing its byte against the pattern
// byte aligned to it, so a transaction is taken every cycle and the result of an
// end-of-scan byte is registered in stage one and then in the output register.
// Input stalls only when an end-of-scan byte reaches the counters while
// the previous result still waits to be taken. A configuration write takes effect
// for a byte accepted at the next clock edge; the window depth is the smaller of
// PATTERN_MAX and 32, and longer patterns never match.
`include "wildcard_byte_pattern_scanner_core_macros.svh"

module wildcard_byte_pattern_scanner_core #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wbps_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            scan_valid,
    output logic                            scan_ready,
    input  wbps_pkg::scan_item_t            scan_item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output wbps_pkg::result_item_t          result_item
);

    localparam int WIN = (PATTERN_MAX < wbps_pkg::PAT_BYTES) ? PATTERN_MAX
                                                             : wbps_pkg::PAT_BYTES;
    localparam int RUN_W = $clog2(WIN + 1);
    localparam int LW = wbps_pkg::LEN_W;

    wbps_pkg::pattern_ctl_t ctl;
    wbps_pkg::tally_step_t  step;
    logic [WIN-1:0][7:0]    ref_bytes;
    logic [WIN-1:0]         care;
    logic [WIN-1:0][7:0]    win_bytes;
    logic [WIN-1:0]         hits;

    logic              accept;
    logic              stall;
    logic              match;
    logic [RUN_W-1:0]  run_length_reg, run_length_next;
    logic [RUN_W-1:0]  run_base;
    logic [RUN_W-1:0]  run_inc;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic              s1_runok_reg;
    logic [31:0]       s1_start_reg;

    wbps_cfg #(
        .WIN (WIN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .ref_bytes (ref_bytes),
        .care      (care)
    );

    genvar j;
    generate
        for (j = 0; j < WIN; j++)
        begin : g_cell
            wbps_cell u_cell (
                .clk      (clk),
                .shift    (accept),
                .byte_in  ((j == 0) ? scan_item.data_byte : win_bytes[(j == 0) ? 0 : j - 1]),
                .ref_byte (ref_bytes[j]),
                .care     (care[j]),
                .byte_out (win_bytes[j]),
                .hit      (hits[j])
            );
        end
    endgenerate

    // A pending end-of-scan byte cannot enter the counters while the output is full.
    assign stall      = s1_valid_reg && s1_last_reg && result_valid && !result_ready;
    assign scan_ready = !stall;
    assign accept     = scan_valid && scan_ready;

    // A region start, or the first byte after a scan ends, sees an empty window.
    always_comb
    begin
        run_base = scan_item.region_start ? '0 : run_length_reg;
        run_inc  = (run_base == RUN_W'(WIN)) ? run_base : RUN_W'(run_base + RUN_W'(1));
        run_length_next = run_length_reg;
        if (accept)
        begin
            run_length_next = scan_item.end_of_scan ? '0 : run_inc;
        end
        s1_valid_next = stall ? s1_valid_reg : accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            run_length_reg <= run_length_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg  <= scan_item.end_of_scan;
            s1_runok_reg <= LW'(run_inc) >= ctl.length;
            s1_start_reg <= scan_item.byte_offset - (32'(ctl.length) - 32'd1);
        end
    end

    assign match = s1_valid_reg && ctl.length_ok && s1_runok_reg && (&hits);

    assign step.fire         = s1_valid_reg && !stall;
    assign step.last         = s1_last_reg;
    assign step.hit          = match;
    assign step.start_offset = s1_start_reg;

    wbps_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result_item  (result_item)
    );

    `WBPS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, step.fire && step.last, result_valid)
    `WBPS_ASSERT_SAME(a_no_match_without_length, clk, rst_n, !ctl.length_ok, !match)
    `WBPS_ASSERT_SAME(a_unique_is_one, clk, rst_n, result_valid,
        result_item.unique_match == (result_item.match_count == 32'd1))
    `WBPS_ASSERT_SAME(a_offset_zero_without_match, clk, rst_n,
        result_valid && (result_item.match_count == 32'd0),
        result_item.first_match_offset == 32'd0)

endmodule
